// File: rtl/assert_macros.svh
// assertion macros shared by the compass calibration rtl
// depends on nothing; users provide clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define CCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/cch_pkg.sv
// shared types, constants and tables for compass calibration and heading
// depends on nothing
package cch_pkg;

  localparam int RAW_W = 13;
  localparam int CAL_W = 16;
  localparam int HDG_W = 9;
  localparam int SUM_W = RAW_W + 1;
  localparam int C_W = RAW_W + 2;
  localparam int HS_W = RAW_W;
  localparam int DIV_W = C_W + HS_W;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int FRAC = 16;
  localparam int CORD_W = 36;
  localparam int ANG_W = 28;
  localparam int ATAN_W = 22;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int RUN_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CCNT_W = $clog2(ATAN_ENTRIES);
  localparam int LAST_AXIS = 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_DIV, ST_STORE, ST_CORD_INIT, ST_CORD, ST_FIN
  } cch_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic div_store;
    logic cord_init;
    logic cord_step;
    logic out_load;
  } cch_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_axis;
    logic cord_done;
  } cch_sts_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [CCNT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // offset = -(min+max)/2, truncated toward zero
  function automatic logic signed [SUM_W-1:0] calc_off(input logic signed [RAW_W-1:0] mn,
                                                       input logic signed [RAW_W-1:0] mx);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] h;
    s = SUM_W'(mn) + SUM_W'(mx);
    h = (s + (s[SUM_W-1] ? SUM_W'(1) : SUM_W'(0))) >>> 1;
    return -h;
  endfunction

  // half-span = max + offset, never negative
  function automatic logic [HS_W-1:0] calc_hs(input logic signed [RAW_W-1:0] mx,
                                              input logic signed [SUM_W-1:0] off);
    logic signed [C_W-1:0] t;
    t = C_W'(mx) + C_W'(off);
    return t[HS_W-1:0];
  endfunction

endpackage

// File: rtl/cch_in_if.sv
// request channel carrying one raw magnetometer sample
// depends on cch_pkg
interface cch_in_if;
  import cch_pkg::*;
  logic valid;
  logic ready;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;
  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

// File: rtl/cch_out_if.sv
// result channel carrying calibrated axes and heading
// depends on cch_pkg
interface cch_out_if;
  import cch_pkg::*;
  logic valid;
  logic ready;
  logic signed [CAL_W-1:0] cal_x;
  logic signed [CAL_W-1:0] cal_y;
  logic signed [CAL_W-1:0] cal_z;
  logic [HDG_W-1:0] heading_deg;
  logic [2:0] unscaled_axes;
  logic heading_held;
  modport source (output valid, cal_x, cal_y, cal_z, heading_deg, unscaled_axes,
                  heading_held, input ready);
  modport sink (input valid, cal_x, cal_y, cal_z, heading_deg, unscaled_axes,
                heading_held, output ready);
endinterface

// File: rtl/cch_ctrl.sv
// sequencer for the calibration datapath: divide per axis, then cordic
// depends on cch_pkg
module cch_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cch_pkg::cch_sts_t  sts,
  output cch_pkg::cch_cmd_t  cmd,
  output cch_pkg::cch_state_t state
);
  import cch_pkg::*;

  cch_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;
  // no request is taken while reset is held
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign state = state_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_INIT;
      ST_INIT:      state_nxt = ST_DIV;
      ST_DIV:       if (sts.div_done) state_nxt = ST_STORE;
      ST_STORE:     state_nxt = sts.last_axis ? ST_CORD_INIT : ST_INIT;
      ST_CORD_INIT: state_nxt = ST_CORD;
      ST_CORD:      if (sts.cord_done) state_nxt = ST_FIN;
      ST_FIN:       if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:      cmd.load = in_valid;
      ST_INIT:      cmd.div_init = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_STORE:     cmd.div_store = 1'b1;
      ST_CORD_INIT: cmd.cord_init = 1'b1;
      ST_CORD:      cmd.cord_step = 1'b1;
      ST_FIN:       cmd.out_load = slot_free;
      default:      cmd = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: rtl/cch_dp.sv
// datapath: min/max tracking, shared restoring divider, vectoring cordic
// depends on cch_pkg
module cch_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cch_pkg::cch_cmd_t               cmd,
  output cch_pkg::cch_sts_t               sts,
  input  logic signed [cch_pkg::RAW_W-1:0] in_raw_x,
  input  logic signed [cch_pkg::RAW_W-1:0] in_raw_y,
  input  logic signed [cch_pkg::RAW_W-1:0] in_raw_z,
  output logic signed [cch_pkg::CAL_W-1:0] out_cal_x,
  output logic signed [cch_pkg::CAL_W-1:0] out_cal_y,
  output logic signed [cch_pkg::CAL_W-1:0] out_cal_z,
  output logic [cch_pkg::HDG_W-1:0]        out_heading_deg,
  output logic [2:0]                       out_unscaled_axes,
  output logic                             out_heading_held
);
  import cch_pkg::*;

  logic signed [RAW_W-1:0] raw_r [3];
  logic signed [RAW_W-1:0] min_r [3];
  logic signed [RAW_W-1:0] max_r [3];
  logic signed [RAW_W-1:0] in_raw [3];
  logic signed [CAL_W-1:0] cal_r [3];
  logic [2:0] flag_r;
  logic [1:0] axis_r;
  logic [HDG_W-1:0] last_r;

  logic [DIV_W-1:0] q_r;
  logic [HS_W-1:0] rem_r;
  logic [HS_W-1:0] dvs_r;
  logic neg_r, unsc_r;
  logic signed [C_W-1:0] c_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic signed [CORD_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [CCNT_W-1:0] ccnt_r;

  assign in_raw[0] = in_raw_x;
  assign in_raw[1] = in_raw_y;
  assign in_raw[2] = in_raw_z;

  // offset, half-span and corrected value of the current axis
  logic signed [SUM_W-1:0] off_sel, off0;
  logic [HS_W-1:0] hs_sel, hs0;
  logic signed [C_W-1:0] c_sel;
  logic [C_W-1:0] c_mag;
  logic [DIV_W-1:0] prod;
  always_comb begin
    off_sel = calc_off(min_r[axis_r], max_r[axis_r]);
    hs_sel = calc_hs(max_r[axis_r], off_sel);
    off0 = calc_off(min_r[0], max_r[0]);
    hs0 = calc_hs(max_r[0], off0);
    c_sel = C_W'(raw_r[axis_r]) + C_W'(off_sel);
    c_mag = c_sel[C_W-1] ? C_W'(-c_sel) : C_W'(c_sel);
    prod = DIV_W'(c_mag) * DIV_W'(hs0);
  end

  // divider trial subtract
  logic [HS_W:0] rem_sh, rem_sub;
  logic fits;
  always_comb begin
    rem_sh = {rem_r, q_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits = (rem_sh >= {1'b0, dvs_r});
  end

  // signed, saturated quotient or unscaled value
  logic signed [CAL_W-1:0] cal_val;
  always_comb begin
    if (unsc_r) cal_val = CAL_W'(c_r);
    else if (neg_r) cal_val = (q_r > DIV_W'(32768)) ? 16'sh8000 : -$signed(q_r[CAL_W-1:0]);
    else cal_val = (q_r > DIV_W'(32767)) ? 16'sh7fff : $signed(q_r[CAL_W-1:0]);
  end

  // cordic micro-rotation
  logic signed [CORD_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] ang;
  always_comb begin
    xs = x_r >>> ccnt_r;
    ys = y_r >>> ccnt_r;
    ang = ANG_W'(atan_q16(ccnt_r));
  end

  // absolute value of calibrated x and y, widened by one bit
  logic signed [CAL_W:0] ax, ay;
  always_comb begin
    ax = cal_r[0][CAL_W-1] ? -(CAL_W+1)'(cal_r[0]) : (CAL_W+1)'(cal_r[0]);
    ay = cal_r[1][CAL_W-1] ? -(CAL_W+1)'(cal_r[1]) : (CAL_W+1)'(cal_r[1]);
  end

  // fold first-quadrant angle by sign, truncate, clamp to the quadrant; hold last heading on a zero axis
  logic signed [ANG_W-1:0] full;
  logic [ANG_W-FRAC-1:0] lo, deg;
  logic xneg, yneg, held;
  logic [HDG_W-1:0] heading;
  always_comb begin
    xneg = cal_r[0][CAL_W-1];
    yneg = cal_r[1][CAL_W-1];
    held = (cal_r[0] == '0) || (cal_r[1] == '0);
    priority if (!xneg && !yneg) begin
      full = z_r;
      lo = '0;
    end else if (xneg && !yneg) begin
      full = (ANG_W'(180) <<< FRAC) - z_r;
      lo = (ANG_W-FRAC)'(90);
    end else if (xneg) begin
      full = (ANG_W'(180) <<< FRAC) + z_r;
      lo = (ANG_W-FRAC)'(180);
    end else begin
      full = (ANG_W'(360) <<< FRAC) - z_r;
      lo = (ANG_W-FRAC)'(270);
    end
    if (full < $signed({1'b0, lo, FRAC'(0)})) deg = lo;
    else deg = full[ANG_W-1:FRAC];
    if (deg > lo + (ANG_W-FRAC)'(89)) deg = lo + (ANG_W-FRAC)'(89);
    heading = held ? last_r : deg[HDG_W-1:0];
  end

  assign sts.div_done = (dcnt_r == DCNT_W'(DIV_W-1));
  assign sts.last_axis = (axis_r == 2'(LAST_AXIS));
  assign sts.cord_done = (ccnt_r == CCNT_W'(RUN_STEPS-1));

  // control-like state: extremes, axis pointer, last heading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
      end
      axis_r <= '0;
      last_r <= '0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < 3; i++) begin
          if (in_raw[i] < min_r[i]) min_r[i] <= in_raw[i];
          if (in_raw[i] > max_r[i]) max_r[i] <= in_raw[i];
        end
        axis_r <= '0;
      end
      if (cmd.div_store) axis_r <= sts.last_axis ? 2'd0 : axis_r + 2'd1;
      if (cmd.out_load && !held) last_r <= heading;
    end
  end

  // sample, divider and cordic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) raw_r[i] <= in_raw[i];
    end
    if (cmd.div_init) begin
      q_r <= prod;
      rem_r <= '0;
      dvs_r <= hs_sel;
      neg_r <= c_sel[C_W-1];
      unsc_r <= (hs_sel == '0);
      c_r <= c_sel;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= fits ? rem_sub[HS_W-1:0] : rem_sh[HS_W-1:0];
      q_r <= {q_r[DIV_W-2:0], fits};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.div_store) begin
      cal_r[axis_r] <= cal_val;
      flag_r[axis_r] <= unsc_r;
    end
    if (cmd.cord_init) begin
      x_r <= CORD_W'(ax) <<< FRAC;
      y_r <= CORD_W'(ay) <<< FRAC;
      z_r <= '0;
      ccnt_r <= '0;
    end
    if (cmd.cord_step) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end
      ccnt_r <= ccnt_r + CCNT_W'(1);
    end
    if (cmd.out_load) begin
      out_cal_x <= cal_r[0];
      out_cal_y <= cal_r[1];
      out_cal_z <= cal_r[2];
      out_heading_deg <= heading;
      out_unscaled_axes <= flag_r;
      out_heading_held <= held;
    end
  end
endmodule

// File: rtl/compass_calibrate_heading.sv
// Hard-iron calibration and compass heading. Each sample widens the per-axis
// min/max, each axis is re-centered and scaled to the x half-span by a shared
// one-bit-per-cycle restoring divider, then a vectoring CORDIC of CORDIC_STEPS
// iterations gives the heading in whole degrees. One sample is in work at a
// time, and the next is taken while a result waits.
// depends on cch_pkg, cch_in_if, cch_out_if, cch_ctrl, cch_dp, assert_macros.svh
module compass_calibrate_heading (
  input logic      clk,
  input logic      rst_n,
  cch_in_if.sink   in_s,
  cch_out_if.source out_s
);
  import cch_pkg::*;
  `include "assert_macros.svh"

  cch_cmd_t cmd;
  cch_sts_t sts;
  cch_state_t state;

  // sequencer
  cch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .out_valid(out_s.valid),
    .out_ready(out_s.ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // arithmetic
  cch_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_raw_x         (in_s.raw_x),
    .in_raw_y         (in_s.raw_y),
    .in_raw_z         (in_s.raw_z),
    .out_cal_x        (out_s.cal_x),
    .out_cal_y        (out_s.cal_y),
    .out_cal_z        (out_s.cal_z),
    .out_heading_deg  (out_s.heading_deg),
    .out_unscaled_axes(out_s.unscaled_axes),
    .out_heading_held (out_s.heading_held)
  );

  // checks
  `CCH_ASSERT(a_busy_after_req, (in_s.valid && in_s.ready) |=> !in_s.ready, "ready after request")
  `CCH_ASSERT(a_held_zero, (out_s.valid && out_s.heading_held) |-> (out_s.cal_x == '0 || out_s.cal_y == '0), "held without zero axis")
  `CCH_ASSERT(a_hdg_range, out_s.valid |-> (out_s.heading_deg <= HDG_W'(359)), "heading out of range")
  `CCH_ASSERT(a_load_fin, cmd.out_load |-> (state == ST_FIN), "result load outside finish")
  `CCH_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_s.valid, "result valid after reset")
endmodule

// File: dv/tb_scoreboard.sv
// compass calibration scoreboard: predicts each sample's calibrated axes and heading
// depends on cch_pkg
class cch_scoreboard;
  typedef struct {
    logic signed [15:0] cal_x, cal_y, cal_z;
    logic [8:0]         heading_deg;
    logic [2:0]         unscaled_axes;
    logic               heading_held;
  } cal_result_t;

  int signed   axis_lo[3];
  int signed   axis_hi[3];
  logic [8:0]  prev_heading;
  cal_result_t pending[$];
  int          errors;
  int          checked;
  int          held_seen;
  int          unscaled_seen;

  // same table as the block, atan(2^-i) in degrees with 16 fraction bits
  static const longint atan_deg[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function void clear();
    foreach (axis_lo[i]) begin
      axis_lo[i] = 0;
      axis_hi[i] = 0;
    end
    prev_heading = '0;
    pending.delete();
    errors = 0;
    checked = 0;
    held_seen = 0;
    unscaled_seen = 0;
  endfunction

  function longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // vectoring cordic on the absolute values, then fold into the quadrant
  function logic [8:0] angle_of(longint cx, longint cy);
    longint x, y, z, xs, ys, full, lo, deg;
    int n;
    x = (cx < 0 ? -cx : cx) <<< 16;
    y = (cy < 0 ? -cy : cy) <<< 16;
    z = 0;
    n = cch_pkg::RUN_STEPS;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_deg[i];
      end else begin
        x -= ys; y += xs; z -= atan_deg[i];
      end
    end
    if (cx > 0 && cy > 0) begin
      full = z; lo = 0;
    end else if (cx < 0 && cy > 0) begin
      full = (180 <<< 16) - z; lo = 90;
    end else if (cx < 0) begin
      full = (180 <<< 16) + z; lo = 180;
    end else begin
      full = (360 <<< 16) - z; lo = 270;
    end
    if (full < (lo <<< 16)) deg = lo;
    else deg = full >>> 16;
    if (deg > lo + 89) deg = lo + 89;
    return deg[8:0];
  endfunction

  // note an accepted sample and queue its expected result
  function void note_sample(logic signed [12:0] rx, logic signed [12:0] ry,
                            logic signed [12:0] rz);
    int signed   raw[3];
    int signed   offs[3];
    int signed   span[3];
    longint      cal[3];
    longint      c;
    cal_result_t r;
    raw[0] = rx; raw[1] = ry; raw[2] = rz;
    r.unscaled_axes = '0;
    for (int i = 0; i < 3; i++) begin
      if (raw[i] < axis_lo[i]) axis_lo[i] = raw[i];
      if (raw[i] > axis_hi[i]) axis_hi[i] = raw[i];
      offs[i] = -((axis_lo[i] + axis_hi[i]) / 2);
      span[i] = axis_hi[i] + offs[i];
    end
    for (int i = 0; i < 3; i++) begin
      c = longint'(raw[i]) + offs[i];
      if (span[i] == 0) begin
        r.unscaled_axes[i] = 1'b1;
        cal[i] = clip16(c);
      end else begin
        cal[i] = clip16((c * span[0]) / span[i]);
      end
    end
    if (cal[0] == 0 || cal[1] == 0) begin
      r.heading_deg = prev_heading;
      r.heading_held = 1'b1;
    end else begin
      r.heading_deg = angle_of(cal[0], cal[1]);
      prev_heading = r.heading_deg;
      r.heading_held = 1'b0;
    end
    r.cal_x = cal[0][15:0];
    r.cal_y = cal[1][15:0];
    r.cal_z = cal[2][15:0];
    pending.push_back(r);
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(cal_result_t got);
    cal_result_t e;
    if (pending.size() == 0) begin
      $error("result arrived with no sample pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (got.heading_held) held_seen++;
    if (got.unscaled_axes != 0) unscaled_seen++;
    if (got.cal_x !== e.cal_x) begin
      $error("cal_x expected %0d actual %0d", e.cal_x, got.cal_x); errors++;
    end
    if (got.cal_y !== e.cal_y) begin
      $error("cal_y expected %0d actual %0d", e.cal_y, got.cal_y); errors++;
    end
    if (got.cal_z !== e.cal_z) begin
      $error("cal_z expected %0d actual %0d", e.cal_z, got.cal_z); errors++;
    end
    if (got.heading_deg !== e.heading_deg) begin
      $error("heading_deg expected %0d actual %0d", e.heading_deg, got.heading_deg);
      errors++;
    end
    if (got.unscaled_axes !== e.unscaled_axes) begin
      $error("unscaled_axes expected %0b actual %0b", e.unscaled_axes, got.unscaled_axes);
      errors++;
    end
    if (got.heading_held !== e.heading_held) begin
      $error("heading_held expected %0b actual %0b", e.heading_held, got.heading_held);
      errors++;
    end
  endfunction
endclass

// File: dv/tb_top.sv
// top of the compass calibration testbench: clock, reset, request driver,
// result monitor with stalls; depends on cch_pkg, cch_in_if, cch_out_if, tb_scoreboard
module tb_top;
  import cch_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic done = 1'b0;
  logic hold_off = 1'b0;

  cch_in_if  in_ch();
  cch_out_if out_ch();

  compass_calibrate_heading dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch.sink),
    .out_s(out_ch.source)
  );

  cch_scoreboard sb = new();

  always #10 clk = ~clk;

  // known values from time zero
  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_x = '0;
    in_ch.raw_y = '0;
    in_ch.raw_z = '0;
    out_ch.ready = 1'b0;
  end

  // random raw value, mostly full range with some extremes and near-zero values
  function automatic logic signed [12:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return -13'sd4096;
      1: return 13'sd4095;
      2: return 13'($urandom_range(0, 6) - 3);
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  // offer one request and hold it until accepted
  task automatic send_sample(logic signed [12:0] x, logic signed [12:0] y,
                             logic signed [12:0] z);
    in_ch.valid <= 1'b1;
    in_ch.raw_x <= x;
    in_ch.raw_y <= y;
    in_ch.raw_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(x, y, z);
  endtask

  task automatic go_idle(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.cal_x, out_ch.cal_y, out_ch.cal_z,
                        out_ch.heading_deg, out_ch.unscaled_axes, out_ch.heading_held});
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 255) < 64) out_ch.ready <= ($urandom_range(0, 3) == 0);
    else if ($urandom_range(0, 15) == 0) out_ch.ready <= 1'b1;
  end

  initial begin
    int burst;
    int sent;
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero sample, held heading, extremes, each quadrant
    send_sample(0, 0, 0);
    send_sample(5, 0, 0);
    send_sample(0, 7, -1);
    send_sample(13'sd4095, 13'sd4095, 13'sd4095);
    send_sample(-13'sd4096, -13'sd4096, -13'sd4096);
    send_sample(1000, 1000, 0);
    send_sample(-1000, 1000, 1);
    send_sample(-1000, -1000, 2);
    send_sample(1000, -1000, 3);
    send_sample(4000, 1, -4000);
    send_sample(1, 4000, 13'sd4095);
    send_sample(-4000, -1, 0);
    send_sample(13'sd2730, -13'sd1365, 13'sd0);
    send_sample(0, 0, 0);
    send_sample(-13'sd4096, 13'sd4095, -13'sd1);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (4) send_sample(rand_raw(), rand_raw(), rand_raw());
    join

    // random bursts with gaps, some stretches back to back
    sent = 0;
    while (sent < 500) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) send_sample(rand_raw(), rand_raw(), rand_raw());
      sent += burst;
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 150));
    end
    go_idle(0);
    done = 1'b1;
  end

  // end of run: drain, settle, report
  initial begin
    wait (done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("checked %0d results; %0d with held heading, %0d with unscaled axes",
             sb.checked, sb.held_seen, sb.unscaled_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/cch_pkg.sv
rtl/cch_in_if.sv
rtl/cch_out_if.sv
rtl/cch_ctrl.sv
rtl/cch_dp.sv
rtl/compass_calibrate_heading.sv
dv/tb_scoreboard.sv
dv/tb_top.sv
